// ===== design/imdt_pkg.sv =====
// ----------------------------------------------------------------------------
// imdt_pkg: shared types and constants
// Word layouts, register map, configuration record and the output
// saturation helper for the decoupling term block.
// ----------------------------------------------------------------------------
package imdt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QBITS         = 32;
    localparam int ADDR_W        = 5;

    localparam logic [2:0] REG_POLES = 3'd0;
    localparam logic [2:0] REG_SIGMA = 3'd1;
    localparam logic [2:0] REG_LS    = 3'd2;
    localparam logic [2:0] REG_VDC   = 3'd3;
    localparam logic [2:0] REG_TR    = 3'd4;

    localparam logic [6:0]  POLES_RST = 7'd4;
    localparam logic [15:0] SIGMA_RST = 16'd6554;
    localparam logic [23:0] LS_RST    = 24'd1677722;
    localparam logic [23:0] VDC_RST   = 24'd102400;
    localparam logic [23:0] TR_RST    = 24'd1677722;

    typedef struct packed {
        logic signed [31:0] rotor_speed;
        logic signed [31:0] current_d;
        logic signed [31:0] current_q;
        logic signed [31:0] magnetizing_current;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] feedforward_d;
        logic signed [31:0] feedforward_q;
        logic signed [31:0] synchronous_speed;
    } out_word_t;

    typedef struct packed {
        logic [6:0]  pole_count;
        logic [15:0] leakage_coefficient;
        logic [23:0] stator_inductance;
        logic [23:0] dc_link_voltage;
        logic [23:0] rotor_time_constant;
    } cfg_t;

    function automatic logic [31:0] sat32(input logic neg, input logic big,
                                          input logic [31:0] mag);
        logic [31:0] res;
        if (neg) begin
            if (big || mag > 32'h8000_0000) begin
                res = 32'h8000_0000;
            end else begin
                res = (~mag) + 32'd1;
            end
        end else begin
            if (big || mag > 32'h7FFF_FFFF) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = mag;
            end
        end
        return res;
    endfunction

endpackage

// ===== design/imdt_cfg.sv =====
// ----------------------------------------------------------------------------
// imdt_cfg: configuration registers
// APB-style register file holding the motor and supply constants.
// ----------------------------------------------------------------------------
module imdt_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [imdt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output imdt_pkg::cfg_t              cfg
);
    import imdt_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (idx)
                REG_POLES: cfg_next.pole_count          = pwdata[6:0];
                REG_SIGMA: cfg_next.leakage_coefficient = pwdata[15:0];
                REG_LS:    cfg_next.stator_inductance   = pwdata[23:0];
                REG_VDC:   cfg_next.dc_link_voltage     = pwdata[23:0];
                REG_TR:    cfg_next.rotor_time_constant = pwdata[23:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_POLES: prdata = 32'(cfg_reg.pole_count);
            REG_SIGMA: prdata = 32'(cfg_reg.leakage_coefficient);
            REG_LS:    prdata = 32'(cfg_reg.stator_inductance);
            REG_VDC:   prdata = 32'(cfg_reg.dc_link_voltage);
            REG_TR:    prdata = 32'(cfg_reg.rotor_time_constant);
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pole_count          <= POLES_RST;
            cfg_reg.leakage_coefficient <= SIGMA_RST;
            cfg_reg.stator_inductance   <= LS_RST;
            cfg_reg.dc_link_voltage     <= VDC_RST;
            cfg_reg.rotor_time_constant <= TR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/imdt_div_cell.sv =====
// ----------------------------------------------------------------------------
// imdt_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, retires one quotient
// bit and hands the word to the next cell.
// ----------------------------------------------------------------------------
module imdt_div_cell #(
    parameter int DW = 24,
    parameter int TW = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [DW-1:0]              in_rem,
    input  logic [DW-1:0]              in_den,
    input  logic [imdt_pkg::QBITS-1:0] in_num,
    input  logic [imdt_pkg::QBITS-1:0] in_q,
    input  logic [TW-1:0]              in_tag,
    output logic                       out_valid,
    output logic [DW-1:0]              out_rem,
    output logic [DW-1:0]              out_den,
    output logic [imdt_pkg::QBITS-1:0] out_num,
    output logic [imdt_pkg::QBITS-1:0] out_q,
    output logic [TW-1:0]              out_tag
);
    import imdt_pkg::*;

    logic             valid_reg;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg;
    logic [QBITS-1:0] num_reg, num_next;
    logic [QBITS-1:0] q_reg, q_next;
    logic [TW-1:0]    tag_reg;
    logic [DW:0]      trial;
    logic [DW:0]      diff;

    always_comb begin
        trial = {in_rem, in_num[QBITS-1]};
        diff  = trial - {1'b0, in_den};
        if (trial >= {1'b0, in_den}) begin
            rem_next = diff[DW-1:0];
            q_next   = {in_q[QBITS-2:0], 1'b1};
        end else begin
            rem_next = trial[DW-1:0];
            q_next   = {in_q[QBITS-2:0], 1'b0};
        end
        num_next = {in_num[QBITS-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            den_reg <= in_den;
            num_reg <= num_next;
            q_reg   <= q_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_num   = num_reg;
    assign out_q     = q_reg;
    assign out_tag   = tag_reg;

endmodule

// ===== design/imdt_div_chain.sv =====
// ----------------------------------------------------------------------------
// imdt_div_chain: row of division cells
// One cell per quotient bit; a new division enters every cycle while en is high.
// ----------------------------------------------------------------------------
module imdt_div_chain #(
    parameter int DW = 24,
    parameter int TW = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [DW-1:0]              in_rem,
    input  logic [DW-1:0]              in_den,
    input  logic [imdt_pkg::QBITS-1:0] in_num,
    input  logic [TW-1:0]              in_tag,
    output logic                       out_valid,
    output logic [imdt_pkg::QBITS-1:0] out_q,
    output logic [TW-1:0]              out_tag
);
    import imdt_pkg::*;

    logic             v_w   [0:QBITS];
    logic [DW-1:0]    rem_w [0:QBITS];
    logic [DW-1:0]    den_w [0:QBITS];
    logic [QBITS-1:0] num_w [0:QBITS];
    logic [QBITS-1:0] q_w   [0:QBITS];
    logic [TW-1:0]    tag_w [0:QBITS];

    assign v_w[0]   = in_valid;
    assign rem_w[0] = in_rem;
    assign den_w[0] = in_den;
    assign num_w[0] = in_num;
    assign q_w[0]   = '0;
    assign tag_w[0] = in_tag;

    for (genvar i = 0; i < QBITS; i++) begin : g_cell
        imdt_div_cell #(.DW(DW), .TW(TW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_w[i]),
            .in_rem    (rem_w[i]),
            .in_den    (den_w[i]),
            .in_num    (num_w[i]),
            .in_q      (q_w[i]),
            .in_tag    (tag_w[i]),
            .out_valid (v_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_den   (den_w[i+1]),
            .out_num   (num_w[i+1]),
            .out_q     (q_w[i+1]),
            .out_tag   (tag_w[i+1])
        );
    end

    assign out_valid = v_w[QBITS];
    assign out_q     = q_w[QBITS];
    assign out_tag   = tag_w[QBITS];

endmodule

// ===== design/induction_motor_decoupling_terms_top.sv =====
// ----------------------------------------------------------------------------
// induction_motor_decoupling_terms_top: IFOC decoupling feed-forward terms
// Slip, synchronous speed and d/q decoupling voltages per current sample.
// ----------------------------------------------------------------------------
// Each input word on the s_ channel carries rotor speed and the d, q and
// magnetizing currents in signed fixed point. For every word one result
// word leaves on the m_ channel with both feed-forward terms and the
// synchronous speed, in input order.
// The block is a fixed pipeline of 72 stages and accepts a new word every
// cycle while s_ready is high. Three rows of 32 division cells set most of
// the depth: one forms the slip quotient, then two in parallel divide the
// feed-forward products by the link voltage.
// The motor constants sit in an APB register file and should only be
// written while no word is in flight.
// Reset clears all stage valid flags and loads the default constants.
// When the receiver stalls, the whole pipeline holds and s_ready drops
// in the same cycle, so no word is lost or repeated.
// ----------------------------------------------------------------------------
module induction_motor_decoupling_terms_top #(
    parameter int FRAC_BITS = imdt_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  imdt_pkg::in_word_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output imdt_pkg::out_word_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [imdt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import imdt_pkg::*;

    localparam int          SLIP_SH   = 24 + FRAC_BITS;
    localparam int          FEED_SH   = 31 + FRAC_BITS;
    localparam logic [31:0] W2_ONE    = 32'd1 << FRAC_BITS;
    localparam logic [38:0] SMALL_LIM = 39'd1 << FRAC_BITS;

    typedef struct packed {
        logic               imr_low;
        logic               num_zero;
        logic               nslip;
        logic               big;
        logic signed [39:0] half;
        logic [47:0]        cdmag;
        logic               sd;
        logic [47:0]        cqmag;
        logic               sq;
    } slip_tag_t;

    typedef struct packed {
        logic neg;
        logic big;
        logic zero;
    } feed_tag_t;

    typedef struct packed {
        feed_tag_t   ft;
        logic [31:0] wmr;
    } feed_d_tag_t;

    cfg_t cfg;
    logic en;

    imdt_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic m_valid_reg;
    out_word_t m_data_reg, m_data_next;

    assign en      = m_ready || !m_valid_reg;
    assign s_ready = en;

    // Stage 1: magnitudes and first products.
    logic               v1_reg;
    logic [55:0]        s1_den_reg, s1_den_next;
    logic               s1_small_reg, s1_small_next;
    logic [31:0]        s1_amag_reg, s1_amag_next;
    logic               s1_nslip_reg, s1_nslip_next;
    logic signed [39:0] s1_p_reg, s1_p_next;
    logic signed [49:0] s1_cd_reg, s1_cd_next;
    logic signed [49:0] s1_cq1_reg, s1_cq1_next;
    logic signed [49:0] s1_cq2_reg, s1_cq2_next;
    logic [31:0]        imag;
    logic [16:0]        coef;

    always_comb begin
        imag = s_data.magnetizing_current[31] ? 32'(-s_data.magnetizing_current)
                                              : 32'(s_data.magnetizing_current);
        coef = 17'h10000 - {1'b0, cfg.leakage_coefficient};
        s1_den_next   = 56'(cfg.rotor_time_constant) * 56'(imag);
        s1_small_next = (39'(imag) * 39'd100) < SMALL_LIM;
        s1_amag_next  = s_data.current_q[31] ? 32'(-s_data.current_q)
                                             : 32'(s_data.current_q);
        s1_nslip_next = s_data.current_q[31] ^ s_data.magnetizing_current[31];
        s1_p_next     = 40'(signed'({1'b0, cfg.pole_count})) * 40'(s_data.rotor_speed);
        s1_cd_next    = 50'(signed'({1'b0, cfg.leakage_coefficient}))
                        * 50'(s_data.current_q);
        s1_cq1_next   = 50'(signed'({1'b0, cfg.leakage_coefficient}))
                        * 50'(s_data.current_d);
        s1_cq2_next   = 50'(signed'({1'b0, coef})) * 50'(s_data.magnetizing_current);
    end

    // Stage 2: overflow test for the slip and signed combinations.
    logic        v2_reg;
    slip_tag_t   s2_tag_reg, s2_tag_next;
    logic [55:0] s2_rem_reg, s2_rem_next;
    logic [55:0] s2_den_reg;
    logic signed [49:0] comb_q;
    logic [87:0] num88;
    logic [87:0] den88;

    always_comb begin
        num88  = 88'(s1_amag_reg) << SLIP_SH;
        den88  = {s1_den_reg, 32'd0};
        comb_q = s1_cq1_reg + s1_cq2_reg;
        s2_tag_next.imr_low  = s1_small_reg;
        s2_tag_next.num_zero = (s1_amag_reg == 32'd0);
        s2_tag_next.nslip    = s1_nslip_reg;
        s2_tag_next.big      = (s1_amag_reg != 32'd0) && (num88 >= den88);
        s2_tag_next.half     = s1_p_reg >>> 1;
        s2_tag_next.cdmag    = s1_cd_reg[49] ? 48'(-s1_cd_reg) : 48'(s1_cd_reg);
        s2_tag_next.sd       = s1_cd_reg[49];
        s2_tag_next.cqmag    = comb_q[49] ? 48'(-comb_q) : 48'(comb_q);
        s2_tag_next.sq       = comb_q[49];
        s2_rem_next          = 56'(s1_amag_reg) << (SLIP_SH - 32);
    end

    logic             sl_valid;
    logic [QBITS-1:0] sl_q;
    slip_tag_t        sl_tag;

    imdt_div_chain #(.DW(56), .TW($bits(slip_tag_t))) u_slip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_rem    (s2_rem_reg),
        .in_den    (s2_den_reg),
        .in_num    ({QBITS{1'b0}}),
        .in_tag    (s2_tag_reg),
        .out_valid (sl_valid),
        .out_q     (sl_q),
        .out_tag   (sl_tag)
    );

    // Stage 3: slip saturation and synchronous speed.
    logic        v3_reg;
    logic [31:0] s3_wmr_reg, s3_wmr_next;
    logic [47:0] s3_cdmag_reg, s3_cqmag_reg;
    logic        s3_sd_reg, s3_sq_reg;
    logic [31:0] w2;
    logic signed [39:0] wmr40;

    always_comb begin
        w2    = sl_tag.imr_low ? W2_ONE
              : (sl_tag.num_zero ? 32'd0 : sat32(sl_tag.nslip, sl_tag.big, sl_q));
        wmr40 = sl_tag.half + 40'(signed'(w2));
        if (wmr40 > 40'sd2147483647) begin
            s3_wmr_next = 32'h7FFF_FFFF;
        end else if (wmr40 < -40'sd2147483648) begin
            s3_wmr_next = 32'h8000_0000;
        end else begin
            s3_wmr_next = wmr40[31:0];
        end
    end

    // Stage 4: inductance times speed magnitude.
    logic        v4_reg;
    logic [55:0] s4_bc_reg, s4_bc_next;
    logic [31:0] s4_wmr_reg;
    logic [47:0] s4_cdmag_reg, s4_cqmag_reg;
    logic        s4_nd_reg, s4_nq_reg;
    logic [31:0] wmag;

    always_comb begin
        wmag       = s3_wmr_reg[31] ? (~s3_wmr_reg) + 32'd1 : s3_wmr_reg;
        s4_bc_next = 56'(cfg.stator_inductance) * 56'(wmag);
    end

    // Stage 5: partial products, sixteen bits of the combination each.
    logic        v5_reg;
    logic [71:0] s5_ppd_reg [3];
    logic [71:0] s5_ppq_reg [3];
    logic [71:0] ppd_next [3];
    logic [71:0] ppq_next [3];
    logic [31:0] s5_wmr_reg;
    logic        s5_nd_reg, s5_nq_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ppd_next[k] = 72'(s4_cdmag_reg[16*k +: 16]) * 72'(s4_bc_reg);
            ppq_next[k] = 72'(s4_cqmag_reg[16*k +: 16]) * 72'(s4_bc_reg);
        end
    end

    // Stage 6: full products.
    logic         v6_reg;
    logic [103:0] s6_pd_reg, s6_pq_reg;
    logic [103:0] pd_next, pq_next;
    logic [31:0]  s6_wmr_reg;
    logic         s6_nd_reg, s6_nq_reg;

    always_comb begin
        pd_next = 104'(s5_ppd_reg[0]) + (104'(s5_ppd_reg[1]) << 16)
                  + (104'(s5_ppd_reg[2]) << 32);
        pq_next = 104'(s5_ppq_reg[0]) + (104'(s5_ppq_reg[1]) << 16)
                  + (104'(s5_ppq_reg[2]) << 32);
    end

    // Stage 7: scaling, overflow tests and link voltage division setup.
    logic         v7_reg;
    feed_d_tag_t  s7_dtag_reg, s7_dtag_next;
    feed_tag_t    s7_qtag_reg, s7_qtag_next;
    logic [23:0]  s7_drem_reg, s7_drem_next, s7_qrem_reg, s7_qrem_next;
    logic [31:0]  s7_dnum_reg, s7_dnum_next, s7_qnum_reg, s7_qnum_next;
    logic [23:0]  s7_vdc_reg;
    logic [103:0] xd, xq, vdc104;

    always_comb begin
        xd     = s6_pd_reg >> FEED_SH;
        xq     = s6_pq_reg >> FEED_SH;
        vdc104 = 104'(cfg.dc_link_voltage) << 32;
        s7_dtag_next.wmr     = s6_wmr_reg;
        s7_dtag_next.ft.neg  = s6_nd_reg;
        s7_dtag_next.ft.zero = (s6_pd_reg == '0);
        s7_dtag_next.ft.big  = (s6_pd_reg != '0)
                               && ((cfg.dc_link_voltage == 24'd0) || (xd >= vdc104));
        s7_qtag_next.neg     = s6_nq_reg;
        s7_qtag_next.zero    = (s6_pq_reg == '0);
        s7_qtag_next.big     = (s6_pq_reg != '0)
                               && ((cfg.dc_link_voltage == 24'd0) || (xq >= vdc104));
        s7_drem_next = xd[55:32];
        s7_qrem_next = xq[55:32];
        s7_dnum_next = xd[31:0];
        s7_qnum_next = xq[31:0];
    end

    logic             fd_valid, fq_valid;
    logic [QBITS-1:0] fd_q, fq_q;
    feed_d_tag_t      fd_tag;
    feed_tag_t        fq_tag;

    imdt_div_chain #(.DW(24), .TW($bits(feed_d_tag_t))) u_feed_d (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .in_rem    (s7_drem_reg),
        .in_den    (s7_vdc_reg),
        .in_num    (s7_dnum_reg),
        .in_tag    (s7_dtag_reg),
        .out_valid (fd_valid),
        .out_q     (fd_q),
        .out_tag   (fd_tag)
    );

    imdt_div_chain #(.DW(24), .TW($bits(feed_tag_t))) u_feed_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .in_rem    (s7_qrem_reg),
        .in_den    (s7_vdc_reg),
        .in_num    (s7_qnum_reg),
        .in_tag    (s7_qtag_reg),
        .out_valid (fq_valid),
        .out_q     (fq_q),
        .out_tag   (fq_tag)
    );

    // Output stage.
    always_comb begin
        if (fd_tag.ft.zero || (!fd_tag.ft.big && fd_q == 32'd0)) begin
            m_data_next.feedforward_d = '0;
        end else begin
            m_data_next.feedforward_d = sat32(fd_tag.ft.neg, fd_tag.ft.big, fd_q);
        end
        if (fq_tag.zero || (!fq_tag.big && fq_q == 32'd0)) begin
            m_data_next.feedforward_q = '0;
        end else begin
            m_data_next.feedforward_q = sat32(fq_tag.neg, fq_tag.big, fq_q);
        end
        m_data_next.synchronous_speed = fd_tag.wmr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= sl_valid;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            m_valid_reg <= fd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_den_reg   <= s1_den_next;
            s1_small_reg <= s1_small_next;
            s1_amag_reg  <= s1_amag_next;
            s1_nslip_reg <= s1_nslip_next;
            s1_p_reg     <= s1_p_next;
            s1_cd_reg    <= s1_cd_next;
            s1_cq1_reg   <= s1_cq1_next;
            s1_cq2_reg   <= s1_cq2_next;

            s2_tag_reg   <= s2_tag_next;
            s2_rem_reg   <= s2_rem_next;
            s2_den_reg   <= s1_den_reg;

            s3_wmr_reg   <= s3_wmr_next;
            s3_cdmag_reg <= sl_tag.cdmag;
            s3_cqmag_reg <= sl_tag.cqmag;
            s3_sd_reg    <= sl_tag.sd;
            s3_sq_reg    <= sl_tag.sq;

            s4_bc_reg    <= s4_bc_next;
            s4_wmr_reg   <= s3_wmr_reg;
            s4_cdmag_reg <= s3_cdmag_reg;
            s4_cqmag_reg <= s3_cqmag_reg;
            s4_nd_reg    <= s3_sd_reg ^ s3_wmr_reg[31];
            s4_nq_reg    <= s3_sq_reg ^ s3_wmr_reg[31];

            for (int k = 0; k < 3; k++) begin
                s5_ppd_reg[k] <= ppd_next[k];
                s5_ppq_reg[k] <= ppq_next[k];
            end
            s5_wmr_reg   <= s4_wmr_reg;
            s5_nd_reg    <= s4_nd_reg;
            s5_nq_reg    <= s4_nq_reg;

            s6_pd_reg    <= pd_next;
            s6_pq_reg    <= pq_next;
            s6_wmr_reg   <= s5_wmr_reg;
            s6_nd_reg    <= s5_nd_reg;
            s6_nq_reg    <= s5_nq_reg;

            s7_dtag_reg  <= s7_dtag_next;
            s7_qtag_reg  <= s7_qtag_next;
            s7_drem_reg  <= s7_drem_next;
            s7_qrem_reg  <= s7_qrem_next;
            s7_dnum_reg  <= s7_dnum_next;
            s7_qnum_reg  <= s7_qnum_next;
            s7_vdc_reg   <= cfg.dc_link_voltage;

            m_data_reg   <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The two link voltage division rows must stay in lockstep.
    a_feed_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        fd_valid == fq_valid)
        else $error("feed-forward division rows out of step");

    // With no link voltage a nonzero term can only be a saturated value.
    a_vdc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && cfg.dc_link_voltage == 24'd0) |->
        (m_data_reg.feedforward_d == 32'sd0
         || m_data_reg.feedforward_d == 32'h7FFF_FFFF
         || m_data_reg.feedforward_d == 32'h8000_0000))
        else $error("feed-forward d not saturated with zero link voltage");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("output word valid right after reset");

endmodule
